// ----- src/apm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_pkg
// Shared types and constants of the attitude PID leg height mixer.
// ----------------------------------------------------------------------------
package apm_pkg;

   // field widths
   localparam int ANGLE_W  = 16;
   localparam int ERR_W    = ANGLE_W + 1;
   localparam int DERR_W   = ERR_W + 1;
   localparam int GAIN_W   = 16;
   localparam int HEIGHT_W = 16;
   localparam int CORR_W   = 7;
   localparam int LEG_NUM  = 4;

   // fixed point formats and limits
   localparam int GAIN_FRAC   = 12;
   localparam int HEIGHT_FRAC = 8;
   localparam int INTEG_LIMIT = 20;
   localparam int OUT_LIMIT   = 45;

   // register reset values
   localparam logic                       ENABLE_RESET = 1'b1;
   localparam logic [GAIN_W-1:0]          GAIN_P_RESET = 16'd2048;
   localparam logic [GAIN_W-1:0]          GAIN_I_RESET = 16'd8;
   localparam logic [GAIN_W-1:0]          GAIN_D_RESET = 16'd4096;
   localparam logic signed [HEIGHT_W-1:0] HMAX_RESET   = 16'sd6400;
   localparam logic signed [HEIGHT_W-1:0] HMIN_RESET   = 16'sd3072;
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_RESET = 16'sd4608;

   // mixing signs per leg, bit set means the correction is added
   localparam logic [LEG_NUM-1:0] LEG_P_PLUS = 4'b0101;
   localparam logic [LEG_NUM-1:0] LEG_R_PLUS = 4'b1100;

   // register indexes
   typedef enum logic [2:0] {
      CSR_ENABLE     = 3'd0,
      CSR_GAIN_P     = 3'd1,
      CSR_GAIN_I     = 3'd2,
      CSR_GAIN_D     = 3'd3,
      CSR_HEIGHT_MAX = 3'd4,
      CSR_HEIGHT_MIN = 3'd5
   } csr_index_type;

   // pipeline control from the top level to the lanes and the mixer
   typedef struct packed {
      logic accept;     // request taken into stage one
      logic s2_load;    // product registers advance
      logic s3_load;    // correction registers advance
      logic s4_update;  // a valid correction pair enters the mixer
   } pipe_ctrl_type;

endpackage

// ----- src/apm_pid_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_pid_lane
// One positional PID channel: error, clamped integral, difference, three
// registered products, then negated sum truncated and limited to a whole correction.
// ----------------------------------------------------------------------------
module apm_pid_lane #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  apm_pkg::pipe_ctrl_type              ctrl,
   input  logic                                enable,
   input  logic [apm_pkg::GAIN_W-1:0]          gain_p,
   input  logic [apm_pkg::GAIN_W-1:0]          gain_i,
   input  logic [apm_pkg::GAIN_W-1:0]          gain_d,
   input  logic signed [apm_pkg::ANGLE_W-1:0]  meas,
   input  logic signed [apm_pkg::ANGLE_W-1:0]  target,
   output logic signed [apm_pkg::CORR_W-1:0]   correction
);
   import apm_pkg::*;

   localparam int INTEG_W = FRAC_BITS + 6;
   localparam int ISUM_W  = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
   localparam int OP_W    = (INTEG_W > DERR_W) ? INTEG_W : DERR_W;
   localparam int PROD_W  = OP_W + GAIN_W + 1;
   localparam int ACC_W   = PROD_W + 2;
   localparam int SHIFT   = FRAC_BITS + GAIN_FRAC;
   localparam logic signed [ISUM_W-1:0] LIM_POS = ISUM_W'(INTEG_LIMIT * (1 << FRAC_BITS));
   localparam logic signed [ISUM_W-1:0] LIM_NEG = -LIM_POS;

   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   last_ff;
   logic signed [ERR_W-1:0]   err;
   logic signed [ISUM_W-1:0]  integ_sum;
   logic signed [DERR_W-1:0]  derr;

   logic signed [ERR_W-1:0]   err_s1_ff;
   logic signed [INTEG_W-1:0] integ_s1_ff;
   logic signed [DERR_W-1:0]  derr_s1_ff;

   logic signed [GAIN_W:0]    kp, ki, kd;
   logic signed [OP_W-1:0]    err_x, integ_x, derr_x;
   logic signed [PROD_W-1:0]  prod_p_ff, prod_i_ff, prod_d_ff;

   logic signed [ACC_W-1:0]   acc, neg;
   logic [ACC_W-1:0]          mag, quot;
   logic [CORR_W-2:0]         qsat;
   logic signed [CORR_W-1:0]  corr_in, corr_ff;

   // error, integral with clamp, difference from the last error
   always_comb begin
      err       = ERR_W'(target) - ERR_W'(meas);
      integ_sum = ISUM_W'(integ_ff) + ISUM_W'(err);
      if (integ_sum > LIM_POS) begin
         integ_in = INTEG_W'(LIM_POS);
      end else if (integ_sum < LIM_NEG) begin
         integ_in = INTEG_W'(LIM_NEG);
      end else begin
         integ_in = INTEG_W'(integ_sum);
      end
      derr = DERR_W'(err) - DERR_W'(last_ff);
   end

   // channel state, changes only for an accepted request while enabled
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
      end else if (ctrl.accept && enable) begin
         integ_ff <= integ_in;
         last_ff  <= err;
      end
   end

   // stage one registers
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         err_s1_ff   <= err;
         integ_s1_ff <= integ_in;
         derr_s1_ff  <= derr;
      end
   end

   // stage two: gain products
   assign kp      = $signed({1'b0, gain_p});
   assign ki      = $signed({1'b0, gain_i});
   assign kd      = $signed({1'b0, gain_d});
   assign err_x   = OP_W'(err_s1_ff);
   assign integ_x = OP_W'(integ_s1_ff);
   assign derr_x  = OP_W'(derr_s1_ff);

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         prod_p_ff <= PROD_W'(kp) * PROD_W'(err_x);
         prod_i_ff <= PROD_W'(ki) * PROD_W'(integ_x);
         prod_d_ff <= PROD_W'(kd) * PROD_W'(derr_x);
      end
   end

   // stage three: negated sum, magnitude truncated and limited
   always_comb begin
      acc  = ACC_W'(prod_p_ff) + ACC_W'(prod_i_ff) + ACC_W'(prod_d_ff);
      neg  = -acc;
      mag  = neg[ACC_W-1] ? ACC_W'(-neg) : ACC_W'(neg);
      quot = mag >> SHIFT;
      qsat = (quot > ACC_W'(OUT_LIMIT)) ? (CORR_W-1)'(OUT_LIMIT) : quot[CORR_W-2:0];
      corr_in = neg[ACC_W-1] ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
   end

   always_ff @(posedge clock) begin
      if (ctrl.s3_load) begin
         corr_ff <= corr_in;
      end
   end

   assign correction = corr_ff;

endmodule

// ----- src/apm_leg_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_leg_mixer
// Merges the pitch and roll corrections into the four stored leg heights while
// enabled, clamps each height and holds the result fields.
// ----------------------------------------------------------------------------
module apm_leg_mixer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  apm_pkg::pipe_ctrl_type               ctrl,
   input  logic                                 enable,
   input  logic signed [apm_pkg::HEIGHT_W-1:0]  height_max,
   input  logic signed [apm_pkg::HEIGHT_W-1:0]  height_min,
   input  logic signed [apm_pkg::CORR_W-1:0]    pitch_in,
   input  logic signed [apm_pkg::CORR_W-1:0]    roll_in,
   output logic signed [apm_pkg::HEIGHT_W-1:0]  heights [apm_pkg::LEG_NUM],
   output logic signed [apm_pkg::CORR_W-1:0]    pitch_out,
   output logic signed [apm_pkg::CORR_W-1:0]    roll_out
);
   import apm_pkg::*;

   localparam int MIX_W = HEIGHT_W + 2;

   logic signed [HEIGHT_W-1:0] height_ff [LEG_NUM];
   logic signed [HEIGHT_W-1:0] height_in [LEG_NUM];
   logic signed [MIX_W-1:0]    ps, rs;
   logic signed [CORR_W-1:0]   pitch_ff, roll_ff;

   // corrections scaled to height units
   assign ps = MIX_W'(pitch_in) <<< HEIGHT_FRAC;
   assign rs = MIX_W'(roll_in) <<< HEIGHT_FRAC;

   // per leg mix and clamp, max first and min last
   for (genvar g = 0; g < LEG_NUM; g++) begin : g_leg
      logic signed [MIX_W-1:0] mix, hi_cut, lo_cut;
      always_comb begin
         mix = MIX_W'(height_ff[g])
             + (LEG_P_PLUS[g] ? ps : -ps)
             + (LEG_R_PLUS[g] ? rs : -rs);
         hi_cut = (mix >= MIX_W'(height_max)) ? MIX_W'(height_max) : mix;
         lo_cut = (hi_cut <= MIX_W'(height_min)) ? MIX_W'(height_min) : hi_cut;
         height_in[g] = HEIGHT_W'(lo_cut);
      end
   end

   // stored heights, the result reports them directly
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEG_NUM; i++) begin
            height_ff[i] <= HEIGHT_RESET;
         end
      end else if (ctrl.s4_update && enable) begin
         height_ff <= height_in;
      end
   end

   // reported corrections, zero while disabled
   always_ff @(posedge clock) begin
      if (ctrl.s4_update) begin
         pitch_ff <= enable ? pitch_in : '0;
         roll_ff  <= enable ? roll_in : '0;
      end
   end

   assign heights   = height_ff;
   assign pitch_out = pitch_ff;
   assign roll_out  = roll_ff;

endmodule

// ----- src/attitude_pid_leg_height_mixer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attitude_pid_leg_height_mixer_top
// Two PID lanes (pitch, roll) feeding a leg height mixer, four stages deep.
// ----------------------------------------------------------------------------
// Four registered stages: error terms, gain products, corrections, leg heights.
// Throughput: one request per cycle unless the response stalls; the integral, last
// error and leg height updates close within a stage, so no item waits on the last.
// Stages advance independently; a stalled result holds only the stages behind it.
// Reset (synchronous): pipeline empty, state cleared, heights 4608, registers
// at their defaults.
module attitude_pid_leg_height_mixer_top #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request: pitch_meas, roll_meas, pitch_target, roll_target (16 each)
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // response: height_front_left, height_rear_left, height_front_right,
   // height_rear_right (16 each), pitch_correction, roll_correction (7 each), pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,
   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import apm_pkg::*;

   logic                       enable_ff;
   logic [GAIN_W-1:0]          gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [HEIGHT_W-1:0] hmax_ff, hmin_ff;

   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic          adv1, adv2, adv3, adv4;
   pipe_ctrl_type ctrl;

   logic signed [CORR_W-1:0]   p_corr, r_corr, p_out, r_out;
   logic signed [HEIGHT_W-1:0] heights [LEG_NUM];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= ENABLE_RESET;
         gain_p_ff <= GAIN_P_RESET;
         gain_i_ff <= GAIN_I_RESET;
         gain_d_ff <= GAIN_D_RESET;
         hmax_ff   <= HMAX_RESET;
         hmin_ff   <= HMIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:     enable_ff <= csr_wdata[0];
            CSR_GAIN_P:     gain_p_ff <= csr_wdata;
            CSR_GAIN_I:     gain_i_ff <= csr_wdata;
            CSR_GAIN_D:     gain_d_ff <= csr_wdata;
            CSR_HEIGHT_MAX: hmax_ff   <= $signed(csr_wdata);
            CSR_HEIGHT_MIN: hmin_ff   <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // stage advance, each stage moves when empty or when its successor moves
   assign adv4 = !v4_ff || rsp_tready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_tready     = adv1;
   assign ctrl.accept    = req_tvalid && adv1;
   assign ctrl.s2_load   = adv2;
   assign ctrl.s3_load   = adv3;
   assign ctrl.s4_update = adv4 && v3_ff;

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // pitch lane
   apm_pid_lane #(.FRAC_BITS(FRAC_BITS)) u_pitch_lane (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .enable     (enable_ff),
      .gain_p     (gain_p_ff),
      .gain_i     (gain_i_ff),
      .gain_d     (gain_d_ff),
      .meas       ($signed(req_tdata[15:0])),
      .target     ($signed(req_tdata[47:32])),
      .correction (p_corr)
   );

   // roll lane
   apm_pid_lane #(.FRAC_BITS(FRAC_BITS)) u_roll_lane (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .enable     (enable_ff),
      .gain_p     (gain_p_ff),
      .gain_i     (gain_i_ff),
      .gain_d     (gain_d_ff),
      .meas       ($signed(req_tdata[31:16])),
      .target     ($signed(req_tdata[63:48])),
      .correction (r_corr)
   );

   // merge into leg heights
   apm_leg_mixer u_mixer (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .enable     (enable_ff),
      .height_max (hmax_ff),
      .height_min (hmin_ff),
      .pitch_in   (p_corr),
      .roll_in    (r_corr),
      .heights    (heights),
      .pitch_out  (p_out),
      .roll_out   (r_out)
   );

   // response
   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {2'b00, r_out, p_out, heights[3], heights[2], heights[1], heights[0]};

endmodule

// ----- src/apm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_checker
// Port level checks of the attitude PID leg height mixer, bound to the top.
// ----------------------------------------------------------------------------
module apm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // requests are refused only while a stalled response is pending
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request refused without a stalled response");

   // corrections stay within the output limit
   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[70:64]) >= -7'sd45)
                  && ($signed(rsp_tdata[70:64]) <= 7'sd45)
                  && ($signed(rsp_tdata[77:71]) >= -7'sd45)
                  && ($signed(rsp_tdata[77:71]) <= 7'sd45)
                  && (rsp_tdata[79:78] == 2'b00))
      else $error("correction out of range");

endmodule

bind attitude_pid_leg_height_mixer_top apm_checker u_apm_checker (.*);
